[hdl/pbbs_pkg.sv]
// pbbs_pkg: shared types, constants and helpers of the pixel block binning sum
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package pbbs_pkg;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_BIN    = 16;
    localparam int DEF_PIXEL_BITS = 16;

    // fixed field widths
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 24;
    localparam int ROW_W      = 12;
    localparam int HGT_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // limits and reset values
    localparam int MAX_HEIGHT = 4096;
    localparam int RST_WIDTH  = 4096;
    localparam int RST_HEIGHT = 4096;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // output queue depth
    localparam int OFIFO_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIN_SIZE,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } t_cfg_reg;

    // per-pixel control from the position logic to the line stage
    typedef struct packed {
        logic valid;
        logic col_end;
        logic first_row;
        logic emit;
        logic row_end;
        logic image_end;
    } t_line_ctl;

    // one result item
    typedef struct packed {
        logic [SUM_W-1:0] bin_sum;
        logic             row_end;
        logic             image_end;
    } t_result;

    // saturating add of two sums
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/pbbs_if.sv]
// pbbs_pix_if, pbbs_bin_if: valid/ready channels of the pixel and bin streams
// depend on pbbs_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface pbbs_pix_if;
    logic                      valid;
    logic                      ready;
    logic [pbbs_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink (input valid, input pixel_value, output ready);
endinterface

interface pbbs_bin_if;
    logic                      valid;
    logic                      ready;
    logic [pbbs_pkg::SUM_W-1:0] bin_sum;
    logic                      row_end;
    logic                      image_end;

    modport source (output valid, output bin_sum, output row_end, output image_end,
                    input ready);
    modport sink (input valid, input bin_sum, input row_end, input image_end,
                  output ready);
endinterface

`default_nettype wire

[hdl/pbbs_ctrl.sv]
// pbbs_ctrl: configuration registers, raster position counters and the
// horizontal partial sum; depends on pbbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbbs_ctrl #(
    parameter int MAX_WIDTH  = pbbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN    = pbbs_pkg::DEF_MAX_BIN,
    parameter int PIXEL_BITS = pbbs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic [pbbs_pkg::PIX_W-1:0]      i_pixel,
    output pbbs_pkg::t_line_ctl                  o_ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_idx,
    output logic [pbbs_pkg::SUM_W-1:0]           o_hp
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int BW  = $clog2(MAX_BIN + 1);
    localparam int CBW = $clog2(MAX_BIN);
    localparam int EW  = WW + 2;
    localparam int HEW = pbbs_pkg::HGT_W + 2;
    localparam int PB  = (PIXEL_BITS < pbbs_pkg::PIX_W) ? PIXEL_BITS : pbbs_pkg::PIX_W;
    localparam int RSTW = (pbbs_pkg::RST_WIDTH < MAX_WIDTH) ? pbbs_pkg::RST_WIDTH : MAX_WIDTH;
    localparam logic [pbbs_pkg::PIX_W-1:0] PIX_MASK =
        {pbbs_pkg::PIX_W{1'b1}} >> (pbbs_pkg::PIX_W - PB);

    // configuration, stored already clamped
    logic [BW-1:0]                r_bin, n_bin;
    logic [WW-1:0]                r_width, n_width;
    logic [pbbs_pkg::HGT_W-1:0]   r_height, n_height;

    // raster position state
    logic [AW-1:0]                r_cp, n_cp;
    logic [pbbs_pkg::ROW_W-1:0]   r_rp, n_rp;
    logic [CBW-1:0]               r_cib, n_cib;
    logic [CBW-1:0]               r_rib, n_rib;
    logic [AW-1:0]                r_oc, n_oc;
    logic [AW-1:0]                r_blk_col, n_blk_col;
    logic [pbbs_pkg::ROW_W-1:0]   r_band_row, n_band_row;
    logic [pbbs_pkg::SUM_W-1:0]   r_hp, n_hp;

    logic [pbbs_pkg::PIX_W-1:0]   pix;
    logic [EW-1:0]                blk_end;
    logic [HEW-1:0]               band_end;
    logic                         col_fit, row_fit, fit, last_col, last_row;
    logic                         cib_last, rib_last, row_wrap, img_wrap;
    logic [pbbs_pkg::SUM_W-1:0]   hp_new;
    logic [31:0]                  v_bin, v_width, v_height;

    function automatic logic [pbbs_pkg::HGT_W-1:0] HGT_W_EXT(
        input logic [pbbs_pkg::ROW_W-1:0] v);
        return pbbs_pkg::HGT_W'(v);
    endfunction

    // block fit and boundary flags
    always_comb begin
        pix      = i_pixel & PIX_MASK;
        blk_end  = EW'(r_blk_col) + EW'(r_bin);
        band_end = HEW'(r_band_row) + HEW'(r_bin);
        col_fit  = blk_end <= EW'(r_width);
        row_fit  = band_end <= HEW'(r_height);
        fit      = col_fit && row_fit;
        last_col = (blk_end + EW'(r_bin)) > EW'(r_width);
        last_row = (band_end + HEW'(r_bin)) > HEW'(r_height);
        cib_last = BW'(r_cib) == (r_bin - BW'(1));
        rib_last = BW'(r_rib) == (r_bin - BW'(1));
        row_wrap = (WW'(r_cp) + WW'(1)) >= r_width;
        img_wrap = (HGT_W_EXT(r_rp) + pbbs_pkg::HGT_W'(1)) >= r_height;
        hp_new   = (r_cib == '0) ? pbbs_pkg::SUM_W'(pix)
                                 : pbbs_pkg::sat_add(r_hp, pbbs_pkg::SUM_W'(pix));
    end

    // control handed to the line stage
    always_comb begin
        o_ctl.valid     = i_accept;
        o_ctl.col_end   = fit && cib_last;
        o_ctl.first_row = r_rib == '0;
        o_ctl.emit      = fit && cib_last && rib_last;
        o_ctl.row_end   = last_col;
        o_ctl.image_end = last_col && last_row;
        o_idx           = r_oc;
        o_hp            = hp_new;
    end

    // clamped register values
    always_comb begin
        v_bin    = 32'(i_cfg_data[4:0]);
        v_width  = 32'(i_cfg_data);
        v_height = 32'(i_cfg_data);
        if (v_bin == 32'd0) v_bin = 32'd1;
        if (v_bin > 32'(MAX_BIN)) v_bin = 32'(MAX_BIN);
        if (v_width == 32'd0) v_width = 32'd1;
        if (v_width > 32'(MAX_WIDTH)) v_width = 32'(MAX_WIDTH);
        if (v_height == 32'd0) v_height = 32'd1;
        if (v_height > 32'(pbbs_pkg::MAX_HEIGHT)) v_height = 32'(pbbs_pkg::MAX_HEIGHT);
    end

    // next state of configuration and positions
    always_comb begin
        n_bin      = r_bin;
        n_width    = r_width;
        n_height   = r_height;
        n_cp       = r_cp;
        n_rp       = r_rp;
        n_cib      = r_cib;
        n_rib      = r_rib;
        n_oc       = r_oc;
        n_blk_col  = r_blk_col;
        n_band_row = r_band_row;
        n_hp       = r_hp;
        if (i_cfg_we) begin
            case (pbbs_pkg::t_cfg_reg'(i_cfg_idx))
                pbbs_pkg::REG_BIN_SIZE:     n_bin = BW'(v_bin);
                pbbs_pkg::REG_IMAGE_WIDTH:  n_width = WW'(v_width);
                pbbs_pkg::REG_IMAGE_HEIGHT: n_height = pbbs_pkg::HGT_W'(v_height);
                default: ;
            endcase
            // any write restarts the image
            n_cp       = '0;
            n_rp       = '0;
            n_cib      = '0;
            n_rib      = '0;
            n_oc       = '0;
            n_blk_col  = '0;
            n_band_row = '0;
            n_hp       = '0;
        end else if (i_accept) begin
            if (fit) n_hp = hp_new;
            if (cib_last) begin
                n_cib     = '0;
                n_oc      = r_oc + AW'(1);
                n_blk_col = r_blk_col + AW'(r_bin);
            end else begin
                n_cib = r_cib + CBW'(1);
            end
            if (row_wrap) begin
                n_cp      = '0;
                n_cib     = '0;
                n_oc      = '0;
                n_blk_col = '0;
                n_hp      = '0;
                n_rp      = r_rp + pbbs_pkg::ROW_W'(1);
                if (rib_last) begin
                    n_rib      = '0;
                    n_band_row = r_band_row + pbbs_pkg::ROW_W'(r_bin);
                end else begin
                    n_rib = r_rib + CBW'(1);
                end
                if (img_wrap) begin
                    n_rp       = '0;
                    n_rib      = '0;
                    n_band_row = '0;
                end
            end else begin
                n_cp = r_cp + AW'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin      <= BW'(1);
            r_width    <= WW'(RSTW);
            r_height   <= pbbs_pkg::HGT_W'(pbbs_pkg::RST_HEIGHT);
            r_cp       <= '0;
            r_rp       <= '0;
            r_cib      <= '0;
            r_rib      <= '0;
            r_oc       <= '0;
            r_blk_col  <= '0;
            r_band_row <= '0;
            r_hp       <= '0;
        end else begin
            r_bin      <= n_bin;
            r_width    <= n_width;
            r_height   <= n_height;
            r_cp       <= n_cp;
            r_rp       <= n_rp;
            r_cib      <= n_cib;
            r_rib      <= n_rib;
            r_oc       <= n_oc;
            r_blk_col  <= n_blk_col;
            r_band_row <= n_band_row;
            r_hp       <= n_hp;
        end
    end

endmodule

`default_nettype wire

[hdl/pbbs_line.sv]
// pbbs_line: column partial sum line memory with read-modify-write and
// write-to-read forwarding; depends on pbbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbbs_line #(
    parameter int MAX_WIDTH = pbbs_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pbbs_pkg::t_line_ctl           i_ctl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  i_idx,
    input  wire logic [pbbs_pkg::SUM_W-1:0]    i_hp,
    output logic                               o_push,
    output pbbs_pkg::t_result                  o_result
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [pbbs_pkg::SUM_W-1:0] r_mem [MAX_WIDTH];
    logic [pbbs_pkg::SUM_W-1:0] r_rd_data;

    pbbs_pkg::t_line_ctl        r_s1_ctl;
    logic [AW-1:0]              r_s1_idx;
    logic [pbbs_pkg::SUM_W-1:0] r_s1_hp;

    logic                       r_wb_valid;
    logic [AW-1:0]              r_wb_idx;
    logic [pbbs_pkg::SUM_W-1:0] r_wb_data;

    logic [pbbs_pkg::SUM_W-1:0] old_sum, col_sum;
    logic                       we;

    // memory: read at accept, write back from the second stage
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_idx];
        if (we) r_mem[r_s1_idx] <= col_sum;
    end

    // second stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl   <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1_ctl   <= i_ctl;
            r_wb_valid <= we;
        end
        r_s1_idx  <= i_idx;
        r_s1_hp   <= i_hp;
        r_wb_idx  <= r_s1_idx;
        r_wb_data <= col_sum;
    end

    // the write in the read cycle is not yet in the read data: forward it
    always_comb begin
        old_sum = (r_wb_valid && (r_wb_idx == r_s1_idx)) ? r_wb_data : r_rd_data;
        col_sum = r_s1_ctl.first_row ? r_s1_hp : pbbs_pkg::sat_add(old_sum, r_s1_hp);
        we      = r_s1_ctl.valid && r_s1_ctl.col_end;
    end

    // result of a finished block
    always_comb begin
        o_push             = r_s1_ctl.valid && r_s1_ctl.emit;
        o_result.bin_sum   = col_sum;
        o_result.row_end   = r_s1_ctl.row_end;
        o_result.image_end = r_s1_ctl.image_end;
    end

endmodule

`default_nettype wire

[hdl/pbbs_ofifo.sv]
// pbbs_ofifo: small output queue that decouples the line stage from the sink
// depends on pbbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbbs_ofifo (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_push,
    input  wire pbbs_pkg::t_result                         i_data,
    input  wire logic                                      i_pop,
    output logic                                           o_valid,
    output pbbs_pkg::t_result                              o_data,
    output logic [$clog2(pbbs_pkg::OFIFO_DEPTH+1)-1:0]     o_count
);

    localparam int DEPTH = pbbs_pkg::OFIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    pbbs_pkg::t_result r_buf [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wp] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_buf[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire

[hdl/pixel_block_binning_sum.sv]
// pixel_block_binning_sum: top level, sums square pixel blocks of a raster image
// depends on pbbs_pkg, pbbs_if, pbbs_ctrl, pbbs_line, pbbs_ofifo
//
// Pixels enter in raster order on i_pix, one transfer per clock cycle while the
// output queue has room; each bin_size by bin_size block yields one sum on o_bin,
// registered through the line stage and the output queue after its bottom-right
// pixel, with row_end on the last bin of an output row and image_end on the last
// bin of the image. Partial rows and columns that do not fill a whole block are
// dropped. The rate is set by one read-modify-write of the column sum line memory
// per pixel (read at transfer, write back in the cycle after, forwarded when the
// next pixel hits the same entry); a two-entry output queue keeps input transfers
// going while a result waits. The line memory needs no clearing pass: the first row
// of each band writes every entry before it is read. Any write on the configuration
// port restarts the image and must be done while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module pixel_block_binning_sum #(
    parameter int MAX_WIDTH  = pbbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_BIN    = pbbs_pkg::DEF_MAX_BIN,
    parameter int PIXEL_BITS = pbbs_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbbs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pbbs_pix_if.sink                             i_pix,
    pbbs_bin_if.source                           o_bin
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(pbbs_pkg::OFIFO_DEPTH + 1);

    pbbs_pkg::t_line_ctl        ctl;
    logic [AW-1:0]              idx;
    logic [pbbs_pkg::SUM_W-1:0] hp;
    logic                       accept, push, pop, q_valid;
    pbbs_pkg::t_result          result, q_data;
    logic [CW-1:0]              q_count;
    logic [CW:0]                occ;

    // input transfer while the queue has room for every result in flight
    always_comb begin
        pop         = q_valid && o_bin.ready;
        occ         = (CW + 1)'(q_count) + (CW + 1)'(push);
        i_pix.ready = (occ < (CW + 1)'(pbbs_pkg::OFIFO_DEPTH))
                   || ((occ == (CW + 1)'(pbbs_pkg::OFIFO_DEPTH)) && pop);
        accept      = i_pix.valid && i_pix.ready;
    end

    pbbs_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_BIN    (MAX_BIN),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pix.pixel_value),
        .o_ctl      (ctl),
        .o_idx      (idx),
        .o_hp       (hp)
    );

    pbbs_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_idx    (idx),
        .i_hp     (hp),
        .o_push   (push),
        .o_result (result)
    );

    pbbs_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    // output channel
    assign o_bin.valid     = q_valid;
    assign o_bin.bin_sum   = q_data.bin_sum;
    assign o_bin.row_end   = q_data.row_end;
    assign o_bin.image_end = q_data.image_end;

endmodule

`default_nettype wire

[hdl/pbbs_checker.sv]
// pbbs_checker: port-level assertions of the binning block and its bind
// depends on pbbs_pkg and the pixel_block_binning_sum top level
`timescale 1ns / 1ps
`default_nettype none

module pbbs_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pbbs_pkg::SUM_W-1:0]  i_bin_sum,
    input wire logic                        i_row_end,
    input wire logic                        i_image_end
);

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // reset leaves the block ready for a pixel
    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // the last bin of the image is also the last bin of its row
    a_image_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_image_end |-> i_row_end)
        else $error("image_end without row_end");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bin_sum)
        && $stable(i_row_end) && $stable(i_image_end))
        else $error("stalled result changed");

endmodule

bind pixel_block_binning_sum pbbs_checker u_pbbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_bin.valid),
    .i_out_ready (o_bin.ready),
    .i_bin_sum   (o_bin.bin_sum),
    .i_row_end   (o_bin.row_end),
    .i_image_end (o_bin.image_end)
);

`default_nettype wire

[sim/tb_pixel_block_binning_sum.sv]
// tb_pixel_block_binning_sum: self-checking bench for the pixel block binning sum
// depends on pbbs_pkg, pbbs_if and pixel_block_binning_sum; needs no files
`timescale 1ns / 1ps

module tb_pixel_block_binning_sum;

    import pbbs_pkg::*;

    localparam int MAX_BIN      = DEF_MAX_BIN;
    localparam int MAX_WIDTH    = DEF_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ROUND_ITEMS  = 250;
    localparam int SHOW_FAILS   = 10;

    // index past the register list, only restarts the image
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_PIX,
        STEP_PIX_KNOWN
    } t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [PIX_W-1:0]        pix;
        t_result                 bin;
    } t_step;

    localparam int N_STEPS = 36;

    // directed opening: reset format, extremes, clamping, dropped edges, restart
    localparam t_step DIRECTED [N_STEPS] = '{
        '{STEP_PIX_KNOWN, 2'd0, 13'd0, 16'hFFFF, '{24'd65535, 1'b0, 1'b0}},
        '{STEP_PIX_KNOWN, 2'd0, 13'd0, 16'h0000, '{24'd0, 1'b0, 1'b0}},
        '{STEP_CFG, REG_BIN_SIZE, 13'd2, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 13'd2, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 13'd2, 16'h0, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'hFFFF, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'hFFFF, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'hFFFF, '0},
        '{STEP_PIX_KNOWN, 2'd0, 13'd0, 16'hFFFF, '{24'd262140, 1'b1, 1'b1}},
        // zero bin size and zero dimensions act as one
        '{STEP_CFG, REG_BIN_SIZE, 13'd0, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 13'd0, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 13'd0, 16'h0, '0},
        '{STEP_PIX_KNOWN, 2'd0, 13'd0, 16'h8000, '{24'd32768, 1'b1, 1'b1}},
        '{STEP_PIX_KNOWN, 2'd0, 13'd0, 16'h7FFF, '{24'd32767, 1'b1, 1'b1}},
        // oversized bin and height clamp, block wider than the image
        '{STEP_CFG, REG_BIN_SIZE, 13'd31, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 13'd3, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 13'd8191, 16'h0, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd1, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd2, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd3, '0},
        // odd width drops the right column, spare index restarts mid row
        '{STEP_CFG, REG_BIN_SIZE, 13'd2, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 13'd5, 16'h0, '0},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 13'd2, 16'h0, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd1, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd2, '0},
        '{STEP_CFG, REG_SPARE, 13'h1555, 16'h0, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd1, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd2, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd3, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd4, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd5, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd6, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd7, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd8, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd9, '0},
        '{STEP_PIX, 2'd0, 13'd0, 16'd10, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pbbs_pix_if pix_if ();
    pbbs_bin_if bin_if ();

    pixel_block_binning_sum DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_bin      (bin_if)
    );

    always #5 i_clk = ~i_clk;

    // binning state mirrored by the bench
    logic [4:0]       cfg_bin;
    logic [12:0]      cfg_width;
    logic [12:0]      cfg_height;
    logic [11:0]      col_pos;
    logic [11:0]      row_pos;
    logic [3:0]       col_in_blk;
    logic [3:0]       row_in_blk;
    logic [11:0]      out_col;
    logic [SUM_W-1:0] hpart;
    logic [SUM_W-1:0] col_line [MAX_WIDTH];

    t_result bins_due [$];
    int      n_fail    = 0;
    int      n_sent    = 0;
    int      n_cycles  = 0;
    int      src_idle  = 26;
    int      sink_idle = 70;

    function automatic logic [4:0] eff_bin();
        if (cfg_bin == 5'd0) return 5'd1;
        if (int'(cfg_bin) > MAX_BIN) return 5'(MAX_BIN);
        return cfg_bin;
    endfunction

    function automatic logic [12:0] eff_width();
        if (cfg_width == 13'd0) return 13'd1;
        if (int'(cfg_width) > MAX_WIDTH) return 13'(MAX_WIDTH);
        return cfg_width;
    endfunction

    function automatic logic [12:0] eff_height();
        if (cfg_height == 13'd0) return 13'd1;
        if (int'(cfg_height) > MAX_HEIGHT) return 13'(MAX_HEIGHT);
        return cfg_height;
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] c);
        logic [SUM_W:0] t;
        t = {1'b0, a} + {1'b0, c};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic restart_image();
        col_pos    = '0;
        row_pos    = '0;
        col_in_blk = '0;
        row_in_blk = '0;
        out_col    = '0;
        hpart      = '0;
    endtask

    // one accepted pixel: update the block sums, give a bin when a block completes
    task automatic predict_bin(input logic [PIX_W-1:0] pix, output bit got_one,
                               output t_result res);
        logic [4:0]       b;
        logic [12:0]      w;
        logic [12:0]      h;
        logic [12:0]      nx;
        logic [12:0]      band_rows;
        logic [SUM_W-1:0] col;
        b         = eff_bin();
        w         = eff_width();
        h         = eff_height();
        nx        = w / b;
        band_rows = (h / b) * b;
        got_one   = 1'b0;
        res       = '0;

        // accumulate only inside whole blocks
        if ({1'b0, out_col} < nx && {1'b0, row_pos} < band_rows) begin
            if (col_in_blk == 4'd0)
                hpart = SUM_W'(pix);
            else
                hpart = sum_sat(hpart, SUM_W'(pix));
            if (5'(col_in_blk) == b - 5'd1) begin
                col = (row_in_blk == 4'd0) ? hpart : sum_sat(col_line[out_col], hpart);
                col_line[out_col] = col;
                if (5'(row_in_blk) == b - 5'd1) begin
                    got_one       = 1'b1;
                    res.bin_sum   = col;
                    res.row_end   = ({1'b0, out_col} == nx - 13'd1);
                    res.image_end = res.row_end
                                 && ({1'b0, row_pos} == band_rows - 13'd1);
                end
            end
        end

        // advance the raster position
        if ({1'b0, col_pos} == w - 13'd1) begin
            col_pos    = '0;
            col_in_blk = '0;
            out_col    = '0;
            hpart      = '0;
            if ({1'b0, row_pos} == h - 13'd1) begin
                row_pos    = '0;
                row_in_blk = '0;
            end else begin
                row_pos    = row_pos + 12'd1;
                row_in_blk = (5'(row_in_blk) == b - 5'd1) ? 4'd0 : row_in_blk + 4'd1;
            end
        end else begin
            col_pos = col_pos + 12'd1;
            if (5'(col_in_blk) == b - 5'd1) begin
                col_in_blk = '0;
                out_col    = out_col + 12'd1;
            end else begin
                col_in_blk = col_in_blk + 4'd1;
            end
        end
    endtask

    // present one pixel until its transfer, then record what it should produce
    task automatic send_pixel(input logic [PIX_W-1:0] value, input bit known,
                              input t_result known_bin);
        bit      got_one;
        t_result res;
        while ($urandom_range(0, 99) < src_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        @(posedge i_clk iff pix_if.ready);
        n_sent++;
        predict_bin(value, got_one, res);
        if (known)
            bins_due.push_back(known_bin);
        else if (got_one)
            bins_due.push_back(res);
    endtask

    task automatic send_pixels(input int count, input bit all_max);
        repeat (count) send_pixel(all_max ? '1 : rand_pixel(), 1'b0, '0);
    endtask

    // block idle: all bins out, then the pipeline latency for pixels with no bin
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BIN_SIZE:     cfg_bin    = value[4:0];
            REG_IMAGE_WIDTH:  cfg_width  = value;
            REG_IMAGE_HEIGHT: cfg_height = value;
            default: ;
        endcase
        restart_image();
    endtask

    task automatic set_format(input logic [CFG_DATA_W-1:0] bin_v,
                              input logic [CFG_DATA_W-1:0] w_v,
                              input logic [CFG_DATA_W-1:0] h_v);
        write_reg(REG_BIN_SIZE, bin_v);
        write_reg(REG_IMAGE_WIDTH, w_v);
        write_reg(REG_IMAGE_HEIGHT, h_v);
    endtask

    // bin checker and receiver stalls
    t_result got_bin;
    t_result want_bin;

    always @(posedge i_clk) begin
        if (i_rst_n && bin_if.valid && bin_if.ready) begin
            got_bin = '{bin_if.bin_sum, bin_if.row_end, bin_if.image_end};
            if (bins_due.size() == 0) begin
                if (n_fail < SHOW_FAILS)
                    $display("unexpected bin transfer: sum %0d row_end %b image_end %b",
                             got_bin.bin_sum, got_bin.row_end, got_bin.image_end);
                n_fail++;
            end else begin
                want_bin = bins_due.pop_front();
                if (got_bin.bin_sum !== want_bin.bin_sum
                        || got_bin.row_end !== want_bin.row_end
                        || got_bin.image_end !== want_bin.image_end) begin
                    if (n_fail < SHOW_FAILS)
                        $display("bin mismatch: sum %0d/%0d row_end %b/%b image_end %b/%b",
                                 want_bin.bin_sum, got_bin.bin_sum,
                                 want_bin.row_end, got_bin.row_end,
                                 want_bin.image_end, got_bin.image_end);
                    n_fail++;
                end
            end
        end
        bin_if.ready <= ($urandom_range(0, 99) >= sink_idle);
    end

    // run watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus
    int                    round_end;
    int                    img_pixels;
    logic [CFG_DATA_W-1:0] bin_v;
    logic [CFG_DATA_W-1:0] w_v;
    logic [CFG_DATA_W-1:0] h_v;

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= '0;
        cfg_bin    = 5'd1;
        cfg_width  = 13'(RST_WIDTH);
        cfg_height = 13'(RST_HEIGHT);
        restart_image();
        foreach (col_line[i]) col_line[i] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_STEPS; i++) begin
            case (DIRECTED[i].kind)
                STEP_CFG:       write_reg(DIRECTED[i].idx, DIRECTED[i].data);
                STEP_PIX:       send_pixel(DIRECTED[i].pix, 1'b0, '0);
                STEP_PIX_KNOWN: send_pixel(DIRECTED[i].pix, 1'b1, DIRECTED[i].bin);
                default: ;
            endcase
        end

        // random formats in three idle mixes
        for (int r = 0; r < 3; r++) begin
            src_idle  = (r == 0) ? 26 : (r == 1) ? 70 : 0;
            sink_idle = (r == 0) ? 70 : (r == 1) ? 26 : 0;
            round_end = n_sent + ROUND_ITEMS;
            while (n_sent < round_end) begin
                bin_v = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                                    : CFG_DATA_W'($urandom_range(1, 4));
                if ($urandom_range(0, 7) == 0)
                    w_v = ($urandom_range(0, 3) == 0) ? '0 : CFG_DATA_W'($urandom_range(17, 40));
                else
                    w_v = CFG_DATA_W'($urandom_range(1, 16));
                if ($urandom_range(0, 7) == 0)
                    h_v = ($urandom_range(0, 3) == 0) ? '0 : CFG_DATA_W'($urandom_range(13, 32));
                else
                    h_v = CFG_DATA_W'($urandom_range(1, 12));
                set_format(bin_v, w_v, h_v);
                img_pixels = int'(eff_width()) * int'(eff_height());
                if ($urandom_range(0, 3) == 0) begin
                    // broken image cut by a restart, then a whole one
                    send_pixels($urandom_range(1, img_pixels), 1'b0);
                    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
                    send_pixels(img_pixels, 1'b0);
                end else begin
                    send_pixels(img_pixels * $urandom_range(1, 2), 1'b0);
                end
            end
        end

        // largest block with every pixel at full scale
        set_format(13'(MAX_BIN), 13'(MAX_BIN), 13'(MAX_BIN));
        send_pixels(MAX_BIN * MAX_BIN, 1'b1);

        wait_idle();
        if (n_fail == 0 && bins_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/pbbs_pkg.sv
hdl/pbbs_if.sv
hdl/pbbs_ctrl.sv
hdl/pbbs_line.sv
hdl/pbbs_ofifo.sv
hdl/pixel_block_binning_sum.sv
hdl/pbbs_checker.sv
sim/tb_pixel_block_binning_sum.sv
